[sv/spcf_pkg.sv]
package spcf_pkg;

	localparam int POS_WIDTH      = 32;
	localparam int UNIT_FRAC_BITS = 14;
	localparam int UNIT_W         = UNIT_FRAC_BITS + 2;

	localparam int DIFF_W      = POS_WIDTH + 1;
	localparam int MAG_W       = POS_WIDTH + 1;
	localparam int SQ_W        = 2 * MAG_W;
	localparam int SUM_W       = 2 * MAG_W + 2;
	localparam int ROOT_W      = SUM_W / 2;
	localparam int SQRT_REM_W  = ROOT_W + 3;
	localparam int DIV_STEPS   = UNIT_FRAC_BITS + 2;
	localparam int DIV_REM_W   = ROOT_W + 1;

	localparam int RADIUS_W    = 31;
	localparam int THRESH_W    = 15;
	localparam int CMP_W       = (UNIT_W > THRESH_W) ? UNIT_W : THRESH_W;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int OUT_FIELD_W = 32;
	localparam int PROD_W      = RADIUS_W + UNIT_W;
	localparam int OFF_W       = PROD_W - UNIT_FRAC_BITS;
	localparam int SAT_W       = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 4;

	localparam int IN_W        = ((6 * POS_WIDTH + 7) / 8) * 8;
	localparam int OUT_RAW_W   = 4 * OUT_FIELD_W + 5 * UNIT_W;
	localparam int OUT_W       = ((OUT_RAW_W + 7) / 8) * 8;

	localparam int LATENCY     = 4 + ROOT_W + DIV_STEPS + 3;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1);
	localparam logic [UNIT_W-1:0]   UNIT_ONE     = UNIT_W'(2 ** UNIT_FRAC_BITS);
	localparam logic [PROD_W-1:0]   ROUND_HALF   = PROD_W'(2 ** (UNIT_FRAC_BITS - 1));

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIUS_FIRST   = 2'd0,
		CFG_RADIUS_SECOND  = 2'd1,
		CFG_AXIS_THRESHOLD = 2'd2
	} cfg_reg_t;

	function automatic logic [OUT_FIELD_W-1:0] sat_out(input logic [SAT_W-1:0] v);
		logic [SAT_W-OUT_FIELD_W:0] top;
		logic [OUT_FIELD_W-1:0]     res;
		top = v[SAT_W-1:OUT_FIELD_W-1];
		if ((&top) || !(|top))
			res = v[OUT_FIELD_W-1:0];
		else if (v[SAT_W-1])
			res = {1'b1, {(OUT_FIELD_W-1){1'b0}}};
		else
			res = {1'b0, {(OUT_FIELD_W-1){1'b1}}};
		return res;
	endfunction

endpackage

[sv/spcf_sqrt.sv]
module spcf_sqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [spcf_pkg::SUM_W-1:0]    rad,
	output logic [spcf_pkg::ROOT_W-1:0]   root
);
	import spcf_pkg::*;

	logic [SUM_W-1:0]      rad_s  [ROOT_W];
	logic [SQRT_REM_W-1:0] rem_s  [ROOT_W];
	logic [ROOT_W-1:0]     root_s [ROOT_W];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_step
		logic [SUM_W-1:0]      rad_in;
		logic [SQRT_REM_W-1:0] rem_in;
		logic [ROOT_W-1:0]     root_in;
		logic [SQRT_REM_W-1:0] cur;
		logic [SQRT_REM_W-1:0] trial;
		logic                  ge;

		if (g == 0) begin : g_first
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
		end

		// one result bit per stage, two radicand bits shifted in
		assign cur   = {rem_in[SQRT_REM_W-3:0], rad_in[SUM_W-1 -: 2]};
		assign trial = SQRT_REM_W'({root_in, 2'b01});
		assign ge    = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g]  <= rad_in << 2;
				rem_s[g]  <= ge ? cur - trial : cur;
				root_s[g] <= {root_in[ROOT_W-2:0], ge};
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

[sv/spcf_div.sv]
module spcf_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [spcf_pkg::MAG_W-1:0]    num,
	input  logic [spcf_pkg::ROOT_W-1:0]   den,
	output logic [spcf_pkg::UNIT_W-1:0]   quo
);
	import spcf_pkg::*;

	logic [DIV_REM_W-1:0] rem_s [DIV_STEPS];
	logic [ROOT_W-1:0]    den_s [DIV_STEPS];
	logic [UNIT_W-1:0]    q_s   [DIV_STEPS];

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		logic [DIV_REM_W-1:0] cur;
		logic [ROOT_W-1:0]    den_in;
		logic [UNIT_W-1:0]    q_in;
		logic                 ge;

		if (g == 0) begin : g_first
			assign cur    = DIV_REM_W'(num);
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign cur    = {rem_s[g-1][DIV_REM_W-2:0], 1'b0};
			assign den_in = den_s[g-1];
			assign q_in   = q_s[g-1];
		end

		assign ge = cur >= DIV_REM_W'(den_in);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= ge ? cur - DIV_REM_W'(den_in) : cur;
				den_s[g] <= den_in;
				q_s[g]   <= {q_in[UNIT_W-2:0], ge};
			end
		end
	end

	// one extra quotient bit, rounded half away from zero
	assign quo = (q_s[DIV_STEPS-1] + UNIT_W'(1)) >> 1;

endmodule

[sv/sphere_pair_contact_frame.sv]
// Contact frame of two spheres: each transaction carries both centres and returns
// the gap, the unit normal from the first to the second centre, a unit tangent in the
// xy plane, the contact point on the first sphere and a coincident flag. One pair is
// taken every cycle while the output is not stalled. It passes the entry registers,
// the square roots, which settle one result bit per stage over 34 stages, the dividers,
// which settle one quotient bit per stage over 16 stages, and the final registers.
// The whole pipeline holds while a result waits on the output; radii and threshold
// are to be written only while no pair is in flight.
module sphere_pair_contact_frame (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// center_a_x, center_a_y, center_a_z, center_b_x, center_b_y, center_b_z
	input  logic [spcf_pkg::IN_W-1:0]         s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// gap, normal_x, normal_y, normal_z, tangent_x, tangent_y, contact_x, contact_y,
	// contact_z
	output logic [spcf_pkg::OUT_W-1:0]        m_axis_tdata,
	// coincident
	output logic                              m_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spcf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spcf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import spcf_pkg::*;

	typedef struct packed {
		logic [2:0][POS_WIDTH-1:0] a;
		logic [2:0][MAG_W-1:0]     mag;
		logic [2:0]                neg;
	} side_t;

	typedef struct packed {
		logic [2:0][POS_WIDTH-1:0] a;
		logic [2:0]                neg;
		logic                      coin;
		logic                      lxy_zero;
		logic [OUT_FIELD_W-1:0]    gap;
	} post_t;

	logic                 adv;
	logic [LATENCY-1:0]   vld_q;
	logic [RADIUS_W-1:0]  r0_q;
	logic [RADIUS_W-1:0]  r1_q;
	logic [THRESH_W-1:0]  thr_q;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[LATENCY-1];
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LATENCY-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q  <= RADIUS_RESET;
			r1_q  <= RADIUS_RESET;
			thr_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_RADIUS_FIRST:   r0_q  <= cfg_data[RADIUS_W-1:0];
				CFG_RADIUS_SECOND:  r1_q  <= cfg_data[RADIUS_W-1:0];
				CFG_AXIS_THRESHOLD: thr_q <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// s1: difference of centres
	logic [2:0][POS_WIDTH-1:0] a_s1;
	logic [2:0][DIFF_W-1:0]    d_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= s_axis_tdata[i*POS_WIDTH +: POS_WIDTH];
				d_s1[i] <= {s_axis_tdata[(i+4)*POS_WIDTH-1],
					s_axis_tdata[(i+3)*POS_WIDTH +: POS_WIDTH]}
					- {s_axis_tdata[(i+1)*POS_WIDTH-1],
					s_axis_tdata[i*POS_WIDTH +: POS_WIDTH]};
			end
		end
	end

	// s2: magnitudes
	logic [2:0][POS_WIDTH-1:0] a_s2;
	logic [2:0][MAG_W-1:0]     mag_s2;
	logic [2:0]                neg_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				a_s2[i]   <= a_s1[i];
				neg_s2[i] <= d_s1[i][DIFF_W-1];
				mag_s2[i] <= d_s1[i][DIFF_W-1] ? MAG_W'(-d_s1[i]) : MAG_W'(d_s1[i]);
			end
		end
	end

	// s3: squares
	logic [2:0][POS_WIDTH-1:0] a_s3;
	logic [2:0][MAG_W-1:0]     mag_s3;
	logic [2:0]                neg_s3;
	logic [2:0][SQ_W-1:0]      sq_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3   <= a_s2;
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= mag_s2[i] * mag_s2[i];
			end
		end
	end

	// s4: sums of squares
	side_t            side_s4;
	logic [SUM_W-1:0] sum_s4;
	logic [SUM_W-1:0] sxy_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4.a   <= a_s3;
			side_s4.mag <= mag_s3;
			side_s4.neg <= neg_s3;
			sum_s4 <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
			sxy_s4 <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]);
		end
	end

	logic [ROOT_W-1:0] len;
	logic [ROOT_W-1:0] lxy;
	side_t             side_q [ROOT_W];

	spcf_sqrt u_sqrt_len (.clk(clk), .en(adv), .rad(sum_s4), .root(len));
	spcf_sqrt u_sqrt_xy  (.clk(clk), .en(adv), .rad(sxy_s4), .root(lxy));

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_s4;
			for (int k = 1; k < ROOT_W; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// divider entry: gap and flags ride beside the dividers
	side_t                side_d;
	post_t                post_in;
	logic [RADIUS_W:0]    rsum;
	logic [SAT_W-1:0]     gap_full;
	logic [UNIT_W-1:0]    qn [3];
	logic [UNIT_W-1:0]    qtx;
	logic [UNIT_W-1:0]    qty;
	post_t                post_q [DIV_STEPS];

	assign side_d   = side_q[ROOT_W-1];
	assign rsum     = {1'b0, r0_q} + {1'b0, r1_q};
	assign gap_full = SAT_W'(len) - SAT_W'(rsum);

	always_comb begin
		post_in.a        = side_d.a;
		post_in.neg      = side_d.neg;
		post_in.coin     = len == '0;
		post_in.lxy_zero = lxy == '0;
		post_in.gap      = sat_out(gap_full);
	end

	for (genvar i = 0; i < 3; i++) begin : g_norm
		spcf_div u_div_n (
			.clk(clk), .en(adv), .num(side_d.mag[i]), .den(len), .quo(qn[i])
		);
	end

	spcf_div u_div_tx (.clk(clk), .en(adv), .num(side_d.mag[1]), .den(lxy), .quo(qtx));
	spcf_div u_div_ty (.clk(clk), .en(adv), .num(side_d.mag[0]), .den(lxy), .quo(qty));

	always_ff @(posedge clk) begin
		if (adv) begin
			post_q[0] <= post_in;
			for (int k = 1; k < DIV_STEPS; k++) begin
				post_q[k] <= post_q[k-1];
			end
		end
	end

	// s6: normal and tangent
	post_t                     pd;
	logic                      fallback;
	logic [2:0][UNIT_W-1:0]    nmag_s6;
	logic [2:0][UNIT_W-1:0]    n_s6;
	logic [UNIT_W-1:0]         tx_s6;
	logic [UNIT_W-1:0]         ty_s6;
	logic [2:0][POS_WIDTH-1:0] a_s6;
	logic [2:0]                neg_s6;
	logic [OUT_FIELD_W-1:0]    gap_s6;
	logic                      coin_s6;

	assign pd       = post_q[DIV_STEPS-1];
	assign fallback = pd.coin || pd.lxy_zero
		|| ((CMP_W'(qn[0]) < CMP_W'(thr_q)) && (CMP_W'(qn[1]) < CMP_W'(thr_q)));

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				nmag_s6[i] <= pd.coin ? '0 : qn[i];
				n_s6[i]    <= pd.coin ? '0 : (pd.neg[i] ? -qn[i] : qn[i]);
			end
			tx_s6   <= fallback ? UNIT_ONE : (pd.neg[1] ? qtx : -qtx);
			ty_s6   <= fallback ? '0 : (pd.neg[0] ? -qty : qty);
			a_s6    <= pd.a;
			neg_s6  <= pd.neg;
			gap_s6  <= pd.gap;
			coin_s6 <= pd.coin;
		end
	end

	// s7: radius times normal
	logic [2:0][PROD_W-1:0]    prod_s7;
	logic [2:0][UNIT_W-1:0]    n_s7;
	logic [UNIT_W-1:0]         tx_s7;
	logic [UNIT_W-1:0]         ty_s7;
	logic [2:0][POS_WIDTH-1:0] a_s7;
	logic [2:0]                neg_s7;
	logic [OUT_FIELD_W-1:0]    gap_s7;
	logic                      coin_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				prod_s7[i] <= PROD_W'(r0_q) * PROD_W'(nmag_s6[i]);
			end
			n_s7    <= n_s6;
			tx_s7   <= tx_s6;
			ty_s7   <= ty_s6;
			a_s7    <= a_s6;
			neg_s7  <= neg_s6;
			gap_s7  <= gap_s6;
			coin_s7 <= coin_s6;
		end
	end

	// s8: contact point, output register
	logic [2:0][OFF_W-1:0]       off;
	logic [2:0][SAT_W-1:0]       c_full;
	logic [2:0][OUT_FIELD_W-1:0] c_s8;
	logic [2:0][UNIT_W-1:0]      n_s8;
	logic [UNIT_W-1:0]           tx_s8;
	logic [UNIT_W-1:0]           ty_s8;
	logic [OUT_FIELD_W-1:0]      gap_s8;
	logic                        coin_s8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off[i]    = OFF_W'((prod_s7[i] + ROUND_HALF) >> UNIT_FRAC_BITS);
			c_full[i] = {{(SAT_W-POS_WIDTH){a_s7[i][POS_WIDTH-1]}}, a_s7[i]}
				+ (neg_s7[i] ? -SAT_W'(off[i]) : SAT_W'(off[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				c_s8[i] <= sat_out(c_full[i]);
			end
			n_s8    <= n_s7;
			tx_s8   <= tx_s7;
			ty_s8   <= ty_s7;
			gap_s8  <= gap_s7;
			coin_s8 <= coin_s7;
		end
	end

	assign m_axis_tdata = OUT_W'({c_s8[2], c_s8[1], c_s8[0], ty_s8, tx_s8,
		n_s8[2], n_s8[1], n_s8[0], gap_s8});
	assign m_axis_tuser = coin_s8;

	a_coin_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> n_s8 == '0 && tx_s8 == UNIT_ONE && ty_s8 == '0)
		else $error("coincident result with nonzero frame");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LATENCY-3] |-> nmag_s6[0] <= UNIT_ONE && nmag_s6[1] <= UNIT_ONE
			&& nmag_s6[2] <= UNIT_ONE)
		else $error("normal component above one");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved during stall");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import spcf_pkg::*;

	typedef struct packed {
		logic [31:0] gap;
		logic [15:0] nx, ny, nz, tx, ty;
		logic [31:0] cx, cy, cz;
		logic        coin;
	} frame_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	frame_t      frame_q[$];
	int          errors;
	int          n_sent;
	int          n_checked;
	int          n_coin;
	logic [30:0] rad_a, rad_b;
	logic [14:0] thresh;
	int          hold_cycles;
	bit          rx_random;

	sphere_pair_contact_frame dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("timeout");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [67:0] isqrt(logic [135:0] s);
		logic [67:0]  r;
		logic [67:0]  c;
		r = '0;
		for (int b = 67; b >= 0; b--) begin
			c = r | (68'd1 << b);
			if ({68'd0, c} * {68'd0, c} <= s)
				r = c;
		end
		return r;
	endfunction

	// round(d * 2^14 / den) half away from zero, |d| <= den
	function automatic logic signed [15:0] unit_ratio(logic signed [33:0] d, logic [67:0] den);
		logic [67:0]  mag;
		logic [101:0] q;
		mag = d < 0 ? 68'(-d) : 68'(d);
		q = (({34'd0, mag} << 15) / {34'd0, den} + 1) >> 1;
		return d < 0 ? -16'(q) : 16'(q);
	endfunction

	function automatic logic [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic frame_t contact_frame(logic [IN_W-1:0] item);
		frame_t               f;
		logic signed [33:0]   a[3], d[3];
		logic signed [15:0]   n[3];
		logic [135:0]         s, sxy;
		logic [67:0]          len, lxy;
		logic signed [63:0]   rsum, q;
		logic [15:0]          mx, my;
		rsum = 64'(rad_a) + 64'(rad_b);
		for (int i = 0; i < 3; i++) begin
			a[i] = 34'(signed'(item[32*i +: 32]));
			d[i] = 34'(signed'(item[32*(i+3) +: 32])) - a[i];
		end
		sxy = 136'(d[0]) * 136'(d[0]) + 136'(d[1]) * 136'(d[1]);
		s = sxy + 136'(d[2]) * 136'(d[2]);
		len = isqrt(s);
		f.tx = 16'd16384;
		f.ty = '0;
		if (len == 0) begin
			f.coin = 1'b1;
			f.gap = clamp32(-rsum);
			n = '{default: '0};
			f.cx = a[0][31:0];
			f.cy = a[1][31:0];
			f.cz = a[2][31:0];
		end else begin
			f.coin = 1'b0;
			f.gap = clamp32(64'(len) - rsum);
			for (int i = 0; i < 3; i++)
				n[i] = unit_ratio(d[i], len);
			mx = n[0] < 0 ? -n[0] : n[0];
			my = n[1] < 0 ? -n[1] : n[1];
			if (!(mx < thresh && my < thresh)) begin
				lxy = isqrt(sxy);
				if (lxy != 0) begin
					f.tx = unit_ratio(-d[1], lxy);
					f.ty = unit_ratio(d[0], lxy);
				end
			end
			for (int i = 0; i < 3; i++) begin
				mx = n[i] < 0 ? -n[i] : n[i];
				q = (64'(rad_a) * 64'(mx) + 64'd8192) >>> 14;
				q = n[i] < 0 ? -q : q;
				if (i == 0) f.cx = clamp32(64'(a[0]) + q);
				if (i == 1) f.cy = clamp32(64'(a[1]) + q);
				if (i == 2) f.cz = clamp32(64'(a[2]) + q);
			end
		end
		f.nx = n[0];
		f.ny = n[1];
		f.nz = n[2];
		return f;
	endfunction

	task automatic send_pair(logic [IN_W-1:0] item, int gap_max);
		int idle;
		idle = $urandom_range(gap_max, 0);
		if (idle > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= item;
		do @(posedge clk); while (!s_axis_tready);
		frame_q.push_back(contact_frame(item));
		n_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_RADIUS_FIRST) rad_a = val[30:0];
		if (idx == CFG_RADIUS_SECOND) rad_b = val[30:0];
		if (idx == CFG_AXIS_THRESHOLD) thresh = val[14:0];
		@(posedge clk);
	endtask

	function automatic logic [IN_W-1:0] pair(int ax, int ay, int az, int bx, int by, int bz);
		return {bz, by, bx, az, ay, ax};
	endfunction

	function automatic logic [31:0] rnd_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(2000, 0)) - 1000;
			default: return $signed($urandom_range(32'h3ffff, 0)) - 32'sh20000;
		endcase
	endfunction

	function automatic logic [IN_W-1:0] rnd_pair();
		logic [31:0] a[3], b[3];
		int m;
		m = $urandom_range(2, 0);
		for (int i = 0; i < 3; i++) begin
			a[i] = rnd_coord(m);
			b[i] = rnd_coord(m);
		end
		case ($urandom_range(9, 0))
			0: b = a;
			1: begin b[0] = a[0]; b[1] = a[1]; end
			2: begin b[0] = a[0] + $signed($urandom_range(6, 0)) - 3;
				b[1] = a[1] + $signed($urandom_range(6, 0)) - 3; end
			default: ;
		endcase
		return {b[2], b[1], b[0], a[2], a[1], a[0]};
	endfunction

	task automatic test_directed();
		int mx, mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		send_pair(pair(0, 0, 0, 0, 0, 0), 2);
		send_pair(pair(5, -7, 9, 5, -7, 9), 2);
		send_pair(pair(mn, mn, mn, mx, mx, mx), 2);
		send_pair(pair(mx, mx, mx, mn, mn, mn), 2);
		send_pair(pair(mx, 0, 0, mn, 0, 0), 2);
		send_pair(pair(0, 0, 0, 0, 0, 65536), 2);
		send_pair(pair(0, 0, 0, 0, 0, -65536), 2);
		send_pair(pair(0, 0, 0, 1, 0, 65536), 2);
		send_pair(pair(0, 0, 0, 3, 4, 0), 2);
		send_pair(pair(0, 0, 0, -1, -1, -1), 2);
		send_pair(pair(mx, mx, mx, mx, mx, mx), 2);
		send_pair(pair(mn, 0, mn, mn, 1, mn), 2);
		send_pair(pair(mx - 5, 0, 0, mx, 0, 0), 2);
		drain();
	endtask

	task automatic test_config_sweep();
		write_reg(CFG_RADIUS_FIRST, 32'hffffffff);
		write_reg(CFG_RADIUS_SECOND, 32'h7fffffff);
		write_reg(CFG_AXIS_THRESHOLD, 32'hffff4000);
		send_pair(pair(0, 0, 0, 0, 0, 0), 2);
		send_pair(pair(32'h7fffffff, 0, 0, 32'h80000000, 0, 0), 2);
		send_pair(pair(0, 0, 0, 100, 100, 1), 2);
		send_pair(pair(0, 0, 0, 1, 1, 100000), 2);
		drain();
		write_reg(CFG_RADIUS_FIRST, 0);
		write_reg(CFG_RADIUS_SECOND, 0);
		write_reg(CFG_AXIS_THRESHOLD, 0);
		write_reg(cfg_reg_t'(2'd3), 32'h1234);
		send_pair(pair(0, 0, 0, 0, 0, 77), 2);
		send_pair(pair(0, 0, 0, 0, 1, 77), 2);
		send_pair(pair(9, 9, 9, 9, 9, 9), 2);
		drain();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_pair(rnd_pair(), ($urandom_range(3, 0) == 0) ? 0 : 16);
		drain();
	endtask

	task automatic test_backpressure();
		hold_cycles = 200;
		for (int i = 0; i < 150; i++)
			send_pair(rnd_pair(), 0);
		drain();
	endtask

	task automatic test_random_config();
		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_RADIUS_FIRST, (p % 2) ? $urandom : $urandom_range(500000, 0));
			write_reg(CFG_RADIUS_SECOND, $urandom);
			write_reg(CFG_AXIS_THRESHOLD, $urandom_range(16384, 0));
			test_random(200);
		end
	endtask

	// receiver side, with a forced long stall on request
	initial begin
		int idle;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (rx_random) begin
				idle = $urandom_range(16, 0);
				if (idle > 0) begin
					m_axis_tready <= 1'b0;
					repeat (idle) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!(m_axis_tvalid && m_axis_tready) && hold_cycles == 0)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		frame_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{gap: m_axis_tdata[31:0], nx: m_axis_tdata[47:32],
				ny: m_axis_tdata[63:48], nz: m_axis_tdata[79:64],
				tx: m_axis_tdata[95:80], ty: m_axis_tdata[111:96],
				cx: m_axis_tdata[143:112], cy: m_axis_tdata[175:144],
				cz: m_axis_tdata[207:176], coin: m_axis_tuser};
			if (frame_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = frame_q.pop_front();
				n_checked++;
				if (want.coin) n_coin++;
				if (got !== want) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_coin = 0;
		hold_cycles = 0;
		rx_random = 1'b1;
		rad_a = 31'(RADIUS_RESET);
		rad_b = 31'(RADIUS_RESET);
		thresh = THRESH_RESET;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_RADIUS_FIRST;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random_config();
		rx_random = 1'b0;
		test_random(300);
		if (frame_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, frame_q.size());
			errors++;
		end
		$display("sent %0d sphere pairs, checked %0d frames (%0d coincident)",
			n_sent, n_checked, n_coin);
		$display("covered radius and threshold extremes, stalls and full-pipe backpressure");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
